### design/als_pkg.sv
// Package: shared types and constants for the addressable LED serializer.
`timescale 1ns / 1ps

package als_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2
    } op_t;

    // Register indexes on the config port (byte address is 4 * index)
    localparam logic [2:0] REG_PERIOD   = 3'd0;
    localparam logic [2:0] REG_ZERO_HI  = 3'd1;
    localparam logic [2:0] REG_ONE_HI   = 3'd2;
    localparam logic [2:0] REG_LED_CNT  = 3'd3;
    localparam logic [2:0] REG_RST_SLOT = 3'd4;

    localparam logic [7:0] PERIOD_RST   = 8'd60;
    localparam logic [7:0] ZERO_HI_RST  = 8'd17;
    localparam logic [7:0] ONE_HI_RST   = 8'd43;
    localparam logic [6:0] LED_CNT_RST  = 7'd7;
    localparam logic [9:0] RST_SLOT_RST = 10'd48;

    localparam int BITS_PER_LED = 24;
    localparam int IN_W         = 32;
    localparam int OUT_W        = 8;

endpackage

### design/addressable_led_serializer.sv
// Top level: single-wire addressable LED serializer with colour store and APB registers.
`timescale 1ns / 1ps

// Channel   | Dir | Word
// s_axis    | in  | op, led_index, green, red, blue: one command or clock tick
// m_axis    | out | line_level, busy_res, write_refused; frame_done on tlast
// apb       | in  | period/high-time/led count/latch slot registers
//
// One word accepted per clock unless the result register stalls; each word
// passes the input register, then the result register. Colour store is a
// 24-bit RAM with a registered read port, prefetching the LED of the next slot.
// Reset clears the store's per-entry valid bits at once; no clearing pass.
// A stalled result register holds the input register, which stalls s_tready.

module addressable_led_serializer #(
    parameter int MAX_LEDS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // op[1:0], led_index[7:2], green[15:8], red[23:16], blue[31:24]
    input  logic [als_pkg::IN_W-1:0]   s_tdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // line_level[0], busy_res[1], write_refused[2], zero[7:3]
    output logic [als_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import als_pkg::*;

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    // LED position keeps counting through the latch slots (up to 1023 / 24 past the data)
    localparam int LW = $clog2(MAX_LEDS + 43);
    localparam int SW = $clog2(MAX_LEDS * BITS_PER_LED + 1024);
    localparam int IW = (LW > 6) ? LW : 6;
    localparam int CW = (LW > 7) ? LW : 7;

    // ---------------- configuration registers ----------------
    logic [7:0] period_reg;
    logic [7:0] zero_hi_reg;
    logic [7:0] one_hi_reg;
    logic [6:0] led_cnt_reg;
    logic [9:0] rst_slot_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RST;
            zero_hi_reg  <= ZERO_HI_RST;
            one_hi_reg   <= ONE_HI_RST;
            led_cnt_reg  <= LED_CNT_RST;
            rst_slot_reg <= RST_SLOT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_PERIOD:   period_reg   <= pwdata[7:0];
                REG_ZERO_HI:  zero_hi_reg  <= pwdata[7:0];
                REG_ONE_HI:   one_hi_reg   <= pwdata[7:0];
                REG_LED_CNT:  led_cnt_reg  <= pwdata[6:0];
                REG_RST_SLOT: rst_slot_reg <= pwdata[9:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_PERIOD:   prdata = {24'd0, period_reg};
            REG_ZERO_HI:  prdata = {24'd0, zero_hi_reg};
            REG_ONE_HI:   prdata = {24'd0, one_hi_reg};
            REG_LED_CNT:  prdata = {25'd0, led_cnt_reg};
            REG_RST_SLOT: prdata = {22'd0, rst_slot_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    logic              in_valid_reg;
    logic [IN_W-1:0]   in_data_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;
    logic              fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    op_t         op;
    logic [5:0]  led_index;
    logic [23:0] wr_word;

    assign op        = op_t'(in_data_reg[1:0]);
    assign led_index = in_data_reg[7:2];
    assign wr_word   = {in_data_reg[15:8], in_data_reg[23:16], in_data_reg[31:24]};

    // ---------------- frame state ----------------
    logic          sending_reg, sending_next;
    logic          pending_reg, pending_next;
    logic          line_reg, line_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [7:0]    tick_reg, tick_next;
    logic [4:0]    bit_reg, bit_next;
    logic [LW-1:0] led_reg, led_next;
    logic          done;
    logic          refused;
    logic          mem_we;

    logic [23:0]   rd_word_reg;
    logic [CW-1:0] led_cnt_ext;
    logic [LW-1:0] leds_sent;
    logic [SW-1:0] data_slots;
    logic [SW-1:0] total_slots;
    logic [8:0]    period_eff;
    logic [8:0]    tick_inc;
    logic [4:0]    bit_sel;
    logic          cur_bit;
    logic [7:0]    high_ticks;
    logic          in_frame;
    logic          in_data;
    logic [IW-1:0] idx_ext;
    logic          idx_ok;

    assign led_cnt_ext = CW'(led_cnt_reg);
    assign leds_sent   = (led_cnt_ext > CW'(MAX_LEDS)) ? LW'(MAX_LEDS) : LW'(led_cnt_ext);
    assign data_slots  = SW'(leds_sent) * SW'(BITS_PER_LED);
    assign total_slots = data_slots + SW'(rst_slot_reg);
    assign period_eff  = (period_reg == 8'd0) ? 9'd1 : {1'b0, period_reg};
    assign tick_inc    = {1'b0, tick_reg} + 9'd1;
    // MSB first within the 24-bit GRB word
    assign bit_sel     = 5'(BITS_PER_LED - 1) - bit_reg;
    assign cur_bit     = rd_word_reg[bit_sel];
    assign high_ticks  = cur_bit ? one_hi_reg : zero_hi_reg;
    assign in_frame    = slot_reg < total_slots;
    assign in_data     = slot_reg < data_slots;
    assign idx_ext     = IW'(led_index);
    assign idx_ok      = idx_ext < IW'(MAX_LEDS);

    always_comb
    begin
        sending_next = sending_reg;
        pending_next = pending_reg;
        line_next    = line_reg;
        slot_next    = slot_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        led_next     = led_reg;
        done         = 1'b0;
        refused      = 1'b0;
        mem_we       = 1'b0;
        if (fire)
        begin
            case (op)
                OP_TICK:
                begin
                    if (sending_reg)
                    begin
                        line_next = in_data && (tick_reg < high_ticks);
                        if (in_frame)
                        begin
                            if (tick_inc >= period_eff)
                            begin
                                tick_next = 8'd0;
                                slot_next = slot_reg + SW'(1);
                                // LED/bit position tracks the slot number, so a
                                // led count raised mid-frame lands on the right word
                                if (bit_reg == 5'(BITS_PER_LED - 1))
                                begin
                                    bit_next = 5'd0;
                                    led_next = led_reg + LW'(1);
                                end
                                else
                                begin
                                    bit_next = bit_reg + 5'd1;
                                end
                            end
                            else
                            begin
                                tick_next = tick_inc[7:0];
                            end
                        end
                        if (slot_next >= total_slots)
                        begin
                            // frame over; a queued start goes out at once
                            done         = 1'b1;
                            sending_next = pending_reg;
                            pending_next = 1'b0;
                            line_next    = 1'b0;
                            slot_next    = '0;
                            tick_next    = 8'd0;
                            bit_next     = 5'd0;
                            led_next     = '0;
                        end
                    end
                    else
                    begin
                        line_next = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    if (sending_reg)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        mem_we = idx_ok;
                    end
                end
                OP_START:
                begin
                    if (sending_reg)
                    begin
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        sending_next = 1'b1;
                        slot_next    = '0;
                        tick_next    = 8'd0;
                        bit_next     = 5'd0;
                        led_next     = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            pending_reg <= 1'b0;
            line_reg    <= 1'b0;
            slot_reg    <= '0;
            tick_reg    <= 8'd0;
            bit_reg     <= 5'd0;
            led_reg     <= '0;
        end
        else
        begin
            sending_reg <= sending_next;
            pending_reg <= pending_next;
            line_reg    <= line_next;
            slot_reg    <= slot_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            led_reg     <= led_next;
        end
    end

    // ---------------- colour store ----------------
    logic [23:0]   mem [MAX_LEDS];
    logic          valid_reg [MAX_LEDS];
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          rd_ok;

    assign waddr = idx_ext[AW-1:0];
    assign raddr = led_next[AW-1:0];
    assign rd_ok = led_next < LW'(MAX_LEDS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEDS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (mem_we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Writes only land while idle, so the prefetch never needs a bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wr_word;
        end
        if (rd_ok && valid_reg[raddr])
        begin
            rd_word_reg <= mem[raddr];
        end
        else
        begin
            rd_word_reg <= 24'd0;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {5'd0, refused, sending_next, line_next};
            out_last_reg <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_done_line_low: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[0])
        else $error("line high on frame end word");

    a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("write refused while idle");

    a_idle_line_low: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> !line_reg && slot_reg == '0 && tick_reg == 8'd0)
        else $error("idle with live frame state");

    a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> sending_reg)
        else $error("start queued while idle");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg != 8'hFF)
        else $error("tick count overflow");

endmodule
